// ----- sv/tttb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tttb_pkg
// Shared types and constants for the text tile blank tracker.
// ----------------------------------------------------------------------------
package tttb_pkg;

  localparam int unsigned TILE_COUNT_DEF = 4096;
  localparam int unsigned TILE_W         = 12;  // tile number field width
  localparam int unsigned ADDR_W         = 17;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned WORD_W         = 32;  // store word: four bytes of a tile
  localparam int unsigned WORDS_PER_TILE = 8;
  localparam int unsigned WSEL_W         = $clog2(WORDS_PER_TILE);
  localparam int unsigned LANES          = WORD_W / BYTE_W;
  localparam int unsigned LANE_W         = $clog2(LANES);
  localparam int unsigned CNT_W          = WSEL_W + 1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_READ,
    ST_MERGE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // store write controls
  typedef struct packed {
    logic word_we;
    logic flag_we;
    logic flag_wdata;
  } st_ctl_t;

endpackage : tttb_pkg
`default_nettype wire

// ----- sv/tttb_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tttb_store
// Tile byte store (32-bit words, eight per tile) and per-tile blank flags.
// ----------------------------------------------------------------------------
module tttb_store #(
  parameter int unsigned TILE_COUNT = tttb_pkg::TILE_COUNT_DEF
) (
  input  wire                                    clk,
  input  wire tttb_pkg::st_ctl_t                 ctl,
  input  wire [$clog2(TILE_COUNT)+tttb_pkg::WSEL_W-1:0] word_waddr,
  input  wire [$clog2(TILE_COUNT)+tttb_pkg::WSEL_W-1:0] word_raddr,
  input  wire [tttb_pkg::WORD_W-1:0]             word_wdata,
  output logic [tttb_pkg::WORD_W-1:0]            word_rdata,
  input  wire [$clog2(TILE_COUNT)-1:0]           flag_waddr,
  input  wire [$clog2(TILE_COUNT)-1:0]           flag_raddr,
  output logic                                   flag_rdata
);
  import tttb_pkg::*;

  localparam int unsigned WORDS = TILE_COUNT * WORDS_PER_TILE;

  logic [WORD_W-1:0] word_mem [WORDS];
  logic              flag_mem [TILE_COUNT];

  always_ff @(posedge clk) begin
    if (ctl.word_we) begin
      word_mem[word_waddr] <= word_wdata;
    end
    word_rdata <= word_mem[word_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.flag_we) begin
      flag_mem[flag_waddr] <= ctl.flag_wdata;
    end
    flag_rdata <= flag_mem[flag_raddr];
  end

endmodule : tttb_store
`default_nettype wire

// ----- sv/tttb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tttb_ctrl
// Sequencer: clear sweep, tile wrap, read-modify-write and word-by-word rescan.
// ----------------------------------------------------------------------------
module tttb_ctrl #(
  parameter int unsigned TILE_COUNT = tttb_pkg::TILE_COUNT_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire                                    in_op,
  input  wire [tttb_pkg::ADDR_W-1:0]             in_addr,
  input  wire [tttb_pkg::BYTE_W-1:0]             in_data,
  input  wire [tttb_pkg::TILE_W-1:0]             in_query,
  input  wire                                    slot_free,
  output logic                                   done,
  output logic [tttb_pkg::TILE_W-1:0]            res_tile,
  output logic                                   res_blank,
  output tttb_pkg::st_ctl_t                      ctl,
  output logic [$clog2(TILE_COUNT)+tttb_pkg::WSEL_W-1:0] word_waddr,
  output logic [$clog2(TILE_COUNT)+tttb_pkg::WSEL_W-1:0] word_raddr,
  output logic [tttb_pkg::WORD_W-1:0]            word_wdata,
  input  wire [tttb_pkg::WORD_W-1:0]             word_rdata,
  output logic [$clog2(TILE_COUNT)-1:0]          flag_waddr,
  output logic [$clog2(TILE_COUNT)-1:0]          flag_raddr,
  input  wire                                    flag_rdata
);
  import tttb_pkg::*;

  localparam int unsigned TW  = $clog2(TILE_COUNT);
  localparam int unsigned AW  = TW + WSEL_W;
  // tile numbers stay below 2**TILE_W, so a larger store never wraps
  localparam int unsigned LIM = (TILE_COUNT > (1 << TILE_W)) ? (1 << TILE_W) : TILE_COUNT;
  localparam logic [TILE_W:0]   LIM_V    = (TILE_W + 1)'(LIM);
  localparam logic [TILE_W-1:0] LIM_LO   = TILE_W'(LIM);
  localparam logic [AW-1:0]     CLR_LAST = AW'(TILE_COUNT * WORDS_PER_TILE - 1);
  localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(WORDS_PER_TILE);

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  op_t                 op_r, op_nxt;
  logic [TILE_W-1:0]   tile_r, tile_nxt;
  logic [TILE_W-1:0]   red_r, red_nxt;
  logic [WSEL_W-1:0]   word_r, word_nxt;
  logic [LANE_W-1:0]   lane_r, lane_nxt;
  logic [BYTE_W-1:0]   data_r, data_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                nz_r, nz_nxt;
  logic                blank_r, blank_nxt;

  logic                red_ge;
  logic [TW-1:0]       st_idx;
  logic [BYTE_W-1:0]   old_byte;
  logic [WORD_W-1:0]   merged;
  logic                need_scan;
  logic                scan_last;

  assign red_ge    = {1'b0, red_r} >= LIM_V;
  assign st_idx    = TW'(red_r);
  assign old_byte  = word_rdata[lane_r*BYTE_W +: BYTE_W];
  assign need_scan = (op_r == OP_WRITE) && (data_r == '0) && !flag_rdata && (old_byte != '0);
  assign scan_last = (cnt_r == CNT_END);

  always_comb begin
    merged = word_rdata;
    for (int i = 0; i < LANES; i++) begin
      if (lane_r == LANE_W'(i)) begin
        merged[i*BYTE_W +: BYTE_W] = data_r;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_REDUCE;
      ST_REDUCE: if (!red_ge) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_MERGE;
      ST_MERGE:  state_nxt = need_scan ? ST_SCAN : ST_DONE;
      ST_SCAN:   if (scan_last) state_nxt = ST_DONE;
      ST_DONE:   if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    done           = 1'b0;
    ctl.word_we    = 1'b0;
    ctl.flag_we    = 1'b0;
    ctl.flag_wdata = 1'b0;
    word_waddr     = {st_idx, word_r};
    word_raddr     = {st_idx, word_r};
    word_wdata     = merged;
    flag_waddr     = st_idx;
    flag_raddr     = st_idx;
    case (state_r)
      ST_CLEAR: begin
        ctl.word_we    = 1'b1;
        ctl.flag_we    = 1'b1;
        ctl.flag_wdata = 1'b1;
        word_waddr     = clr_r;
        word_wdata     = '0;
        flag_waddr     = clr_r[AW-1:WSEL_W];
      end
      ST_IDLE:  in_ready = 1'b1;
      ST_MERGE: begin
        if (op_r == OP_WRITE) begin
          ctl.word_we = 1'b1;
          ctl.flag_we = (data_r != '0);
        end
      end
      ST_SCAN: begin
        word_raddr = {st_idx, cnt_r[WSEL_W-1:0]};
        if (scan_last) begin
          ctl.flag_we    = 1'b1;
          ctl.flag_wdata = !(nz_r || (word_rdata != '0));
        end
      end
      ST_DONE:  done = slot_free;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    clr_nxt   = clr_r;
    op_nxt    = op_r;
    tile_nxt  = tile_r;
    red_nxt   = red_r;
    word_nxt  = word_r;
    lane_nxt  = lane_r;
    data_nxt  = data_r;
    cnt_nxt   = cnt_r;
    nz_nxt    = nz_r;
    blank_nxt = blank_r;
    case (state_r)
      ST_CLEAR: clr_nxt = clr_r + AW'(1);
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt   = op_t'(in_op);
          tile_nxt = (op_t'(in_op) == OP_WRITE) ? in_addr[ADDR_W-1:5] : in_query;
          red_nxt  = (op_t'(in_op) == OP_WRITE) ? in_addr[ADDR_W-1:5] : in_query;
          // in-tile swizzle: word from bits 2:0, lane from ~bit 4 and bit 3
          word_nxt = in_addr[2:0];
          lane_nxt = {~in_addr[4], in_addr[3]};
          data_nxt = in_data;
        end
      end
      ST_REDUCE: if (red_ge) red_nxt = red_r - LIM_LO;
      ST_MERGE: begin
        cnt_nxt = '0;
        nz_nxt  = 1'b0;
        if (op_r == OP_WRITE && data_r != '0) blank_nxt = 1'b0;
        else                                 blank_nxt = flag_rdata;
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        // read data is registered, so it belongs to the address issued in the cycle before
        if (cnt_r != '0) nz_nxt = nz_r || (word_rdata != '0);
        if (scan_last) blank_nxt = !(nz_r || (word_rdata != '0));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    tile_r  <= tile_nxt;
    red_r   <= red_nxt;
    word_r  <= word_nxt;
    lane_r  <= lane_nxt;
    data_r  <= data_nxt;
    cnt_r   <= cnt_nxt;
    nz_r    <= nz_nxt;
    blank_r <= blank_nxt;
  end

  assign res_tile  = tile_r;
  assign res_blank = blank_r;

  a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (ctl.word_we && word_wdata == '0 && ctl.flag_wdata))
    else $error("clear sweep must write zero bytes and set flags");

  a_scan_no_word_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !ctl.word_we)
    else $error("word store written during rescan");

  a_flag_set_source: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.flag_we && ctl.flag_wdata && state_r != ST_CLEAR) |-> (state_r == ST_SCAN))
    else $error("blank flag set outside rescan");

  a_tile_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> ({1'b0, red_r} < LIM_V))
    else $error("store tile index not wrapped");

endmodule : tttb_ctrl
`default_nettype wire

// ----- sv/text_tile_blank_tracker.sv -----
`default_nettype none
// Sequence: an accepted input passes through REDUCE, READ and MERGE to DONE,
//   which waits for a free output slot before out_tvalid; a write that triggers
//   a rescan adds SCAN (eight word reads), and REDUCE repeats one wrap step at a
//   time while the tile number is >= TILE_COUNT. Throughput: one item at a time.
// Reset: after rst_n goes high a clearing sweep zeroes the store and sets all
//   flags; in_tready stays low until the sweep ends.
// ----------------------------------------------------------------------------
// text_tile_blank_tracker
// Text tile store with per-tile blank flags, tracked on byte writes.
// ----------------------------------------------------------------------------
module text_tile_blank_tracker #(
  parameter int unsigned TILE_COUNT = tttb_pkg::TILE_COUNT_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [39:0] in_tdata,   // address[16:0], data[24:17], query_tile[36:25]
  input  wire        in_tuser,   // operation
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [15:0] out_tdata  // tile[11:0], blank[12]
);
  import tttb_pkg::*;

  localparam int unsigned TW = $clog2(TILE_COUNT);
  localparam int unsigned AW = TW + WSEL_W;

  st_ctl_t             ctl;
  logic [AW-1:0]       word_waddr, word_raddr;
  logic [WORD_W-1:0]   word_wdata, word_rdata;
  logic [TW-1:0]       flag_waddr, flag_raddr;
  logic                flag_rdata;
  logic                done, slot_free;
  logic [TILE_W-1:0]   res_tile;
  logic                res_blank;

  logic                out_valid_r;
  logic [TILE_W-1:0]   out_tile_r;
  logic                out_blank_r;

  assign slot_free = !out_valid_r || out_tready;

  tttb_ctrl #(.TILE_COUNT(TILE_COUNT)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_addr    (in_tdata[16:0]),
    .in_data    (in_tdata[24:17]),
    .in_query   (in_tdata[36:25]),
    .slot_free  (slot_free),
    .done       (done),
    .res_tile   (res_tile),
    .res_blank  (res_blank),
    .ctl        (ctl),
    .word_waddr (word_waddr),
    .word_raddr (word_raddr),
    .word_wdata (word_wdata),
    .word_rdata (word_rdata),
    .flag_waddr (flag_waddr),
    .flag_raddr (flag_raddr),
    .flag_rdata (flag_rdata)
  );

  tttb_store #(.TILE_COUNT(TILE_COUNT)) u_store (
    .clk        (clk),
    .ctl        (ctl),
    .word_waddr (word_waddr),
    .word_raddr (word_raddr),
    .word_wdata (word_wdata),
    .word_rdata (word_rdata),
    .flag_waddr (flag_waddr),
    .flag_raddr (flag_raddr),
    .flag_rdata (flag_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_tile_r  <= res_tile;
      out_blank_r <= res_blank;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_blank_r, out_tile_r};

endmodule : text_tile_blank_tracker
`default_nettype wire

// ----- sim/text_tile_blank_checker.sv -----
// ----------------------------------------------------------------------------
// text_tile_blank_checker
// Watches both streams of the tile tracker, keeps its own copy of the tile
// bytes and blank flags, and checks each returned tile/flag item in order.
// ----------------------------------------------------------------------------
module text_tile_blank_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // address[16:0], data[24:17], query_tile[36:25]
  input  logic        in_tuser,   // operation
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // tile[11:0], blank[12]
  output int          fail_count,
  output int          flags_pending,
  output int          results_seen
);
  import tttb_pkg::*;

  localparam int unsigned STORE_TILES = TILE_COUNT_DEF;
  localparam int unsigned TILE_BYTES  = 32;

  typedef struct packed {
    logic [TILE_W-1:0] tile;
    logic              blank;
  } tile_flag_t;

  logic [BYTE_W-1:0] tile_mem [STORE_TILES*TILE_BYTES];
  bit                blank_mem [STORE_TILES];
  tile_flag_t        flag_expect_q [$];
  int                errs;
  int                seen;

  // apply one item to the shadow store and return the flag it reports
  function automatic tile_flag_t track_item(input op_t op, input logic [ADDR_W-1:0] addr,
                                            input logic [BYTE_W-1:0] wbyte,
                                            input logic [TILE_W-1:0] qtile);
    tile_flag_t  res;
    logic [4:0]  off;
    logic [4:0]  sw;
    int unsigned tnum;
    int unsigned slot;
    int unsigned base;
    logic [7:0]  prior;
    bit          all_zero;
    if (op == OP_WRITE) begin
      off  = addr[4:0];
      sw   = (((off ^ 5'h10) & 5'h18) >> 3) | ((off & 5'h07) << 2);
      tnum = addr[ADDR_W-1:5];
      slot = tnum % STORE_TILES;
      base = slot * TILE_BYTES;
      prior = tile_mem[base + sw];
      tile_mem[base + sw] = wbyte;
      if (wbyte != 8'h00) begin
        blank_mem[slot] = 1'b0;
      end else if (!blank_mem[slot] && prior != 8'h00) begin
        all_zero = 1'b1;
        for (int i = 0; i < TILE_BYTES; i++) begin
          if (tile_mem[base + i] != 8'h00) all_zero = 1'b0;
        end
        blank_mem[slot] = all_zero;
      end
    end else begin
      tnum = qtile;
      slot = tnum % STORE_TILES;
    end
    res.tile  = tnum[TILE_W-1:0];
    res.blank = blank_mem[slot];
    return res;
  endfunction

  always @(posedge clk) begin
    tile_flag_t want;
    if (!rst_n) begin
      foreach (tile_mem[i]) tile_mem[i] = '0;
      foreach (blank_mem[i]) blank_mem[i] = 1'b1;
      flag_expect_q.delete();
      errs = 0;
      seen = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen++;
        if (flag_expect_q.size() == 0) begin
          $error("result item with none expected: tile %0d blank %0d",
                 out_tdata[11:0], out_tdata[12]);
          errs++;
        end else begin
          want = flag_expect_q.pop_front();
          if (out_tdata[11:0] !== want.tile) begin
            $error("tile: expected %0d, actual %0d", want.tile, out_tdata[11:0]);
            errs++;
          end
          if (out_tdata[12] !== want.blank) begin
            $error("blank: expected %0d, actual %0d", want.blank, out_tdata[12]);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        flag_expect_q.push_back(track_item(op_t'(in_tuser), in_tdata[16:0],
                                           in_tdata[24:17], in_tdata[36:25]));
      end
    end
    fail_count    <= errs;
    flags_pending <= flag_expect_q.size();
    results_seen  <= seen;
  end

endmodule

// ----- sim/text_tile_blank_tracker_tb.sv -----
// ----------------------------------------------------------------------------
// text_tile_blank_tracker_tb
// Drives byte writes and flag reads into the tile tracker with random gaps
// and back-pressure; a checker beside the block predicts every flag item.
// ----------------------------------------------------------------------------
module text_tile_blank_tracker_tb;
  import tttb_pkg::*;

  localparam int RAND_ITEMS   = 550;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOT_TILES    = 6;
  localparam int HOLD_CYCLES  = 400;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  int fail_count;
  int flags_pending;
  int results_seen;
  bit tx_gaps    = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_tile_blank_tracker DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  text_tile_blank_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .flags_pending(flags_pending),
    .results_seen (results_seen)
  );

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input op_t op, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] wbyte, input logic [TILE_W-1:0] qtile);
    while (tx_gaps && $urandom_range(99) < 24) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {3'b000, qtile, wbyte, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver: random stalls, one long hold-off, and a stretch with no stalls
  initial begin : rx_side
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 100) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (results_seen >= 200 && results_seen < 320) begin
        out_tready = 1'b1;
      end else begin
        out_tready = ($urandom_range(99) >= 24);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stim
    logic [TILE_W-1:0] hot [HOT_TILES];
    logic [TILE_W-1:0] t;
    logic [4:0]        off;
    logic [BYTE_W-1:0] wb;
    int                r;
    int                rand_sent;
    bit                paused;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // blank at reset, both ends of the tile range
    send_item(OP_READ,  17'h00000, 8'h00, 12'h000);
    send_item(OP_READ,  17'h00000, 8'h00, 12'hFFF);
    // zero into a blank tile: no rescan
    send_item(OP_WRITE, 17'h00000, 8'h00, 12'h000);
    send_item(OP_WRITE, 17'h00000, 8'hFF, 12'h000);
    send_item(OP_WRITE, 17'h00001, 8'h01, 12'h000);
    // zero over nonzero, other byte still set
    send_item(OP_WRITE, 17'h00000, 8'h00, 12'h000);
    // zero onto zero
    send_item(OP_WRITE, 17'h00000, 8'h00, 12'h000);
    // last nonzero byte cleared: rescan finds the tile blank
    send_item(OP_WRITE, 17'h00001, 8'h00, 12'h000);
    send_item(OP_READ,  17'h00000, 8'h00, 12'h000);
    send_item(OP_WRITE, 17'h1FFFF, 8'hFF, 12'h000);
    send_item(OP_WRITE, 17'h1FFFF, 8'h00, 12'hFFF);
    send_item(OP_READ,  17'h1FFFF, 8'hFF, 12'hFFF);
    // offsets either side of the swizzle's half-tile flip
    send_item(OP_WRITE, 17'h000B0, 8'h80, 12'h000);
    send_item(OP_WRITE, 17'h000AF, 8'h7F, 12'h000);
    send_item(OP_WRITE, 17'h000B0, 8'h00, 12'h000);
    send_item(OP_READ,  17'h00000, 8'h00, 12'h005);
    send_item(OP_WRITE, 17'h000AF, 8'h00, 12'h000);
    send_item(OP_READ,  17'h00000, 8'h00, 12'h005);
    // unused fields carry junk
    send_item(OP_WRITE, 17'h0AAAA, 8'h55, 12'hFFF);
    send_item(OP_READ,  17'h15555, 8'hAA, 12'hAAA);

    foreach (hot[i]) hot[i] = TILE_W'($urandom);
    rand_sent = 0;
    paused    = 1'b0;
    while (rand_sent < RAND_ITEMS) begin
      tx_gaps = !(rand_sent >= 180 && rand_sent < 300);
      if (!paused && rand_sent >= 350) begin
        // let the block drain completely before going on
        paused    = 1'b1;
        in_tvalid = 1'b0;
        do @(posedge clk); while (flags_pending != 0);
        @(negedge clk);
      end
      r  = $urandom_range(99);
      t  = hot[$urandom_range(HOT_TILES-1)];
      wb = $urandom_range(1) ? 8'h00 : BYTE_W'($urandom);
      if (r < 3) begin
        // clear a whole hot tile byte by byte
        for (int k = 0; k < 32; k++) begin
          send_item(OP_WRITE, {t, 5'(k)}, 8'h00, TILE_W'($urandom));
        end
        send_item(OP_READ, ADDR_W'($urandom), BYTE_W'($urandom), t);
        rand_sent += 33;
      end else if (r < 48) begin
        off = ($urandom_range(99) < 80) ? 5'($urandom_range(3)) : 5'($urandom);
        send_item(OP_WRITE, {t, off}, wb, TILE_W'($urandom));
        rand_sent++;
      end else if (r < 63) begin
        send_item(OP_READ, ADDR_W'($urandom), BYTE_W'($urandom), t);
        rand_sent++;
      end else if (r < 85) begin
        send_item(OP_WRITE, ADDR_W'($urandom), wb, TILE_W'($urandom));
        rand_sent++;
      end else begin
        send_item(OP_READ, ADDR_W'($urandom), BYTE_W'($urandom), TILE_W'($urandom));
        rand_sent++;
      end
    end
    in_tvalid = 1'b0;

    do @(posedge clk); while (flags_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/tttb_pkg.sv
sv/tttb_store.sv
sv/tttb_ctrl.sv
sv/text_tile_blank_tracker.sv
sim/text_tile_blank_checker.sv
sim/text_tile_blank_tracker_tb.sv
